@@ rtl/core/bfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared constants of the Bloom filter: configuration indices and reset
// values, hash constants, operation and status codes, multiplier operands.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 1'd1;

  localparam logic [16:0] BIT_COUNT_RST  = 17'd65536;
  localparam logic [4:0]  HASH_COUNT_RST = 5'd4;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  localparam logic [1:0] ST_DISABLED   = 2'd0;
  localparam logic [1:0] ST_PENDING    = 2'd1;
  localparam logic [1:0] ST_COMPACTING = 2'd2;
  localparam logic [1:0] ST_ENABLED    = 2'd3;

  localparam logic [1:0] MSEL_K1 = 2'd0;
  localparam logic [1:0] MSEL_K2 = 2'd1;
  localparam logic [1:0] MSEL_H1 = 2'd2;
  localparam logic [1:0] MSEL_H2 = 2'd3;

  localparam logic [63:0] MM_C1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_F1  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2  = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MM_AD1 = 64'h0000000052dce729;
  localparam logic [63:0] MM_AD2 = 64'h0000000038495ab5;

endpackage

@@ rtl/core/bloom_filter_with_status.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_with_status
// Bloom filter over a bit RAM, keyed by MurmurHash3 x64 128, with a status
// machine (disabled, pending, compacting, enabled).
//
// Usage: each input transaction carries one key byte (add or query) or a
// status request. Bytes are buffered until key_last; the last byte of a key
// and every status request yield one output transaction. For a finished key,
// each seed runs a set-up step, one pass per full 16-byte block, a pass for a
// partial tail block and finalisation through one shared 32x32 multiplier
// (three partial products per 64-bit product), then a bit-serial modulo
// and a bit RAM write (add) or read (query); queries stop at the first clear
// bit. A done step then hands the result to the output register.
// Status requests answer in the cycle after acceptance.
// Reset, and every move to disabled, runs a clearing pass over all MAX_BITS
// bits of the bit RAM, during which no input transaction is taken.
// The output is held in a register: while the receiver stalls, no input
// transaction is accepted and a finished key waits at its last step.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i.
// ----------------------------------------------------------------------------
module bloom_filter_with_status #(
  parameter int unsigned MAX_BITS      = 65536,
  parameter int unsigned MAX_HASHES    = 16,
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [7:0]                     key_byte_i,
  input  logic                           key_last_i,
  input  logic [1:0]                     target_status_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           maybe_present_o,
  output logic [1:0]                     status_now_o,
  output logic                           key_too_long_o
);

  localparam int unsigned AW  = $clog2(MAX_BITS);
  localparam int unsigned MW  = $clog2(MAX_BITS + 1);
  localparam int unsigned KAW = $clog2(MAX_KEY_BYTES);
  localparam int unsigned LW  = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned NW  = $clog2(MAX_HASHES + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLEAR = 5'd1;
  localparam logic [4:0] S_SEED  = 5'd2;
  localparam logic [4:0] S_LOAD  = 5'd3;
  localparam logic [4:0] S_MUL   = 5'd4;
  localparam logic [4:0] S_B1    = 5'd5;
  localparam logic [4:0] S_B2    = 5'd6;
  localparam logic [4:0] S_B3    = 5'd7;
  localparam logic [4:0] S_B4    = 5'd8;
  localparam logic [4:0] S_B5    = 5'd9;
  localparam logic [4:0] S_B6    = 5'd10;
  localparam logic [4:0] S_T1    = 5'd11;
  localparam logic [4:0] S_T2    = 5'd12;
  localparam logic [4:0] S_T3    = 5'd13;
  localparam logic [4:0] S_T4    = 5'd14;
  localparam logic [4:0] S_F0    = 5'd15;
  localparam logic [4:0] S_F1    = 5'd16;
  localparam logic [4:0] S_F2    = 5'd17;
  localparam logic [4:0] S_F3    = 5'd18;
  localparam logic [4:0] S_F4    = 5'd19;
  localparam logic [4:0] S_F5    = 5'd20;
  localparam logic [4:0] S_F6    = 5'd21;
  localparam logic [4:0] S_F7    = 5'd22;
  localparam logic [4:0] S_F8    = 5'd23;
  localparam logic [4:0] S_MOD   = 5'd24;
  localparam logic [4:0] S_PRB   = 5'd25;
  localparam logic [4:0] S_PRW   = 5'd26;
  localparam logic [4:0] S_DONE  = 5'd27;

  // control registers
  logic [4:0]    state_q, state_d;
  logic [4:0]    mul_ret_q, mul_ret_d;
  logic [1:0]    msub_q, msub_d;
  logic [1:0]    mul_sel_q, mul_sel_d;
  logic [4:0]    ld_cnt_q, ld_cnt_d;
  logic [LW-1:0] base_q, base_d;
  logic [LW-1:0] remn_q, remn_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] key_len_q, key_len_d;
  logic          ovf_q, ovf_d;
  logic [NW-1:0] seed_q, seed_d;
  logic [NW-1:0] n_q, n_d;
  logic          is_add_q, is_add_d;
  logic          answer_q, answer_d;
  logic [5:0]    mcnt_q, mcnt_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [1:0]    stat_q, stat_d;
  logic [16:0]   bit_count_q, bit_count_d;
  logic [4:0]    hash_count_q, hash_count_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [63:0]   h1_q, h1_d, h2_q, h2_d, k1_q, k1_d, k2_q, k2_d;
  logic [63:0]   acc_q, acc_d, mul_k_q, mul_k_d;
  logic [MW-1:0] rem_q, rem_d;
  logic          maybe_q, maybe_d, too_long_q, too_long_d;
  logic [1:0]    out_stat_q, out_stat_d;

  // memory ports
  logic          kr_we, fr_we, fr_wdata, fr_rdata;
  logic [KAW-1:0] kr_addr;
  logic [7:0]    kr_rdata;
  logic [AW-1:0] fr_addr;

  bfs_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (kr_we),
    .addr_i (kr_addr),
    .wdata_i(key_byte_i),
    .rdata_o(kr_rdata)
  );

  bfs_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_bit_ram (
    .clk_i  (clk_i),
    .we_i   (fr_we),
    .addr_i (fr_addr),
    .wdata_i(fr_wdata),
    .rdata_o(fr_rdata)
  );

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  // effective modulus and probe count
  logic [31:0]   bc32, m32, hc32, n32;
  logic [MW-1:0] modulus;
  always_comb begin
    bc32 = 32'(bit_count_q);
    if (bc32 == 32'd0) begin
      m32 = 32'd1;
    end else if (bc32 > 32'(MAX_BITS)) begin
      m32 = 32'(MAX_BITS);
    end else begin
      m32 = bc32;
    end
    hc32 = 32'(hash_count_q);
    n32  = (hc32 > 32'(MAX_HASHES)) ? 32'(MAX_HASHES) : hc32;
  end
  assign modulus = MW'(m32);

  // shared 32x32 multiplier
  logic [63:0] mul_a;
  logic [31:0] mx_a, mx_b;
  logic [63:0] prod;
  always_comb begin
    case (mul_sel_q)
      bfs_pkg::MSEL_K1: mul_a = k1_q;
      bfs_pkg::MSEL_K2: mul_a = k2_q;
      bfs_pkg::MSEL_H1: mul_a = h1_q;
      default:          mul_a = h2_q;
    endcase
    case (msub_q)
      2'd0:    begin mx_a = mul_a[31:0];  mx_b = mul_k_q[31:0];  end
      2'd1:    begin mx_a = mul_a[31:0];  mx_b = mul_k_q[63:32]; end
      default: begin mx_a = mul_a[63:32]; mx_b = mul_k_q[31:0];  end
    endcase
  end
  assign prod = {32'd0, mx_a} * {32'd0, mx_b};

  logic          in_ready, in_acc;
  logic          key_room, ovf_eff, active, key_sel;
  logic [1:0]    stat_nxt;
  logic          go_dis;
  logic [4:0]    chunk_len;
  logic [LW-1:0] kaddr_sum;
  logic [MW:0]   mod_t;
  logic [NW-1:0] seed_nxt;
  logic          out_free;

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready  = (state_q == S_IDLE) && out_free;
  assign in_acc    = in_valid_i && in_ready;
  assign key_room  = key_len_q < LW'(MAX_KEY_BYTES);
  assign active    = (stat_q == bfs_pkg::ST_COMPACTING) || (stat_q == bfs_pkg::ST_ENABLED);
  assign chunk_len = (remn_q >= LW'(16)) ? 5'd16 : remn_q[4:0];
  assign kaddr_sum = base_q + LW'(ld_cnt_q);
  assign mod_t     = {rem_q, h1_q[63]};
  assign seed_nxt  = seed_q + NW'(1);
  assign ovf_eff   = ovf_q || !key_room;
  assign key_sel   = (operation_i == bfs_pkg::OP_ADD) || (operation_i == bfs_pkg::OP_QUERY);

  // status transition table
  always_comb begin
    stat_nxt = stat_q;
    go_dis   = 1'b0;
    unique case (stat_q)
      bfs_pkg::ST_DISABLED: begin
        if (target_status_i == bfs_pkg::ST_ENABLED) stat_nxt = bfs_pkg::ST_PENDING;
      end
      bfs_pkg::ST_PENDING: begin
        if (target_status_i == bfs_pkg::ST_DISABLED) go_dis = 1'b1;
        else if (target_status_i == bfs_pkg::ST_COMPACTING) stat_nxt = bfs_pkg::ST_COMPACTING;
      end
      bfs_pkg::ST_COMPACTING: begin
        if (target_status_i == bfs_pkg::ST_DISABLED) go_dis = 1'b1;
        else if (target_status_i == bfs_pkg::ST_ENABLED) stat_nxt = bfs_pkg::ST_ENABLED;
      end
      default: begin
        if (target_status_i == bfs_pkg::ST_DISABLED) go_dis = 1'b1;
        else if (target_status_i == bfs_pkg::ST_COMPACTING) stat_nxt = bfs_pkg::ST_COMPACTING;
      end
    endcase
    if (go_dis) stat_nxt = bfs_pkg::ST_DISABLED;
  end

  always_comb begin
    state_d      = state_q;
    mul_ret_d    = mul_ret_q;
    msub_d       = msub_q;
    mul_sel_d    = mul_sel_q;
    mul_k_d      = mul_k_q;
    ld_cnt_d     = ld_cnt_q;
    base_d       = base_q;
    remn_d       = remn_q;
    len_d        = len_q;
    key_len_d    = key_len_q;
    ovf_d        = ovf_q;
    seed_d       = seed_q;
    n_d          = n_q;
    is_add_d     = is_add_q;
    answer_d     = answer_q;
    mcnt_d       = mcnt_q;
    clr_cnt_d    = clr_cnt_q;
    stat_d       = stat_q;
    bit_count_d  = bit_count_q;
    hash_count_d = hash_count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    h1_d         = h1_q;
    h2_d         = h2_q;
    k1_d         = k1_q;
    k2_d         = k2_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    maybe_d      = maybe_q;
    too_long_d   = too_long_q;
    out_stat_d   = out_stat_q;
    kr_we        = 1'b0;
    kr_addr      = kaddr_sum[KAW-1:0];
    fr_we        = 1'b0;
    fr_wdata     = 1'b0;
    fr_addr      = rem_q[AW-1:0];

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfs_pkg::CFG_BIT_COUNT:  bit_count_d  = cfg_wdata_i;
        bfs_pkg::CFG_HASH_COUNT: hash_count_d = cfg_wdata_i[4:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        kr_addr = key_len_q[KAW-1:0];
        if (in_acc && operation_i == bfs_pkg::OP_STATUS) begin
          stat_d      = stat_nxt;
          out_valid_d = 1'b1;
          maybe_d     = 1'b0;
          too_long_d  = 1'b0;
          out_stat_d  = stat_nxt;
          if (go_dis) begin
            clr_cnt_d = '0;
            state_d   = S_CLEAR;
          end
        end else if (in_acc && key_sel) begin
          if (key_room) begin
            kr_we     = 1'b1;
            key_len_d = key_len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (key_last_i) begin
            key_len_d = '0;
            ovf_d     = 1'b0;
            if (ovf_eff || !active || n32 == 32'd0) begin
              out_valid_d = 1'b1;
              maybe_d     = (operation_i == bfs_pkg::OP_QUERY);
              too_long_d  = ovf_eff;
              out_stat_d  = stat_q;
            end else begin
              len_d    = key_len_q + LW'(1);
              is_add_d = (operation_i == bfs_pkg::OP_ADD);
              answer_d = 1'b1;
              seed_d   = '0;
              n_d      = NW'(n32);
              state_d  = S_SEED;
            end
          end
        end
      end
      S_CLEAR: begin
        fr_we     = 1'b1;
        fr_addr   = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(MAX_BITS - 1)) state_d = S_IDLE;
      end
      S_SEED: begin
        h1_d     = 64'(seed_q);
        h2_d     = 64'(seed_q);
        base_d   = '0;
        remn_d   = len_q;
        ld_cnt_d = '0;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        // read byte ld_cnt, capture byte ld_cnt-1; zero-fill past the chunk
        if (ld_cnt_q != 5'd0) begin
          k1_d = {k2_q[7:0], k1_q[63:8]};
          k2_d = {((ld_cnt_q - 5'd1) < chunk_len) ? kr_rdata : 8'd0, k2_q[63:8]};
        end
        ld_cnt_d = ld_cnt_q + 5'd1;
        if (ld_cnt_q == 5'd16) begin
          msub_d  = 2'd0;
          state_d = S_MUL;
          if (remn_q >= LW'(16)) begin
            mul_sel_d = bfs_pkg::MSEL_K1;
            mul_k_d   = bfs_pkg::MM_C1;
            mul_ret_d = S_B1;
          end else begin
            mul_sel_d = bfs_pkg::MSEL_K2;
            mul_k_d   = bfs_pkg::MM_C2;
            mul_ret_d = S_T1;
          end
        end
      end
      S_MUL: begin
        msub_d = msub_q + 2'd1;
        if (msub_q == 2'd0) begin
          acc_d = prod;
        end else if (msub_q == 2'd1) begin
          acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
        end else begin
          msub_d  = 2'd0;
          state_d = mul_ret_q;
          case (mul_sel_q)
            bfs_pkg::MSEL_K1: k1_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
            bfs_pkg::MSEL_K2: k2_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
            bfs_pkg::MSEL_H1: h1_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
            default:          h2_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
          endcase
        end
      end
      S_B1: begin
        k1_d      = rotl(k1_q, 31);
        mul_sel_d = bfs_pkg::MSEL_K1;
        mul_k_d   = bfs_pkg::MM_C2;
        mul_ret_d = S_B2;
        state_d   = S_MUL;
      end
      S_B2: begin
        h1_d    = rotl(h1_q ^ k1_q, 27) + h2_q;
        state_d = S_B3;
      end
      S_B3: begin
        h1_d      = (h1_q << 2) + h1_q + bfs_pkg::MM_AD1;
        mul_sel_d = bfs_pkg::MSEL_K2;
        mul_k_d   = bfs_pkg::MM_C2;
        mul_ret_d = S_B4;
        state_d   = S_MUL;
      end
      S_B4: begin
        k2_d      = rotl(k2_q, 33);
        mul_sel_d = bfs_pkg::MSEL_K2;
        mul_k_d   = bfs_pkg::MM_C1;
        mul_ret_d = S_B5;
        state_d   = S_MUL;
      end
      S_B5: begin
        h2_d    = rotl(h2_q ^ k2_q, 31) + h1_q;
        state_d = S_B6;
      end
      S_B6: begin
        h2_d     = (h2_q << 2) + h2_q + bfs_pkg::MM_AD2;
        base_d   = base_q + LW'(16);
        remn_d   = remn_q - LW'(16);
        ld_cnt_d = '0;
        state_d  = (remn_q == LW'(16)) ? S_F0 : S_LOAD;
      end
      // tail: a zero k2 when the tail is short leaves h2 unchanged
      S_T1: begin
        k2_d      = rotl(k2_q, 33);
        mul_sel_d = bfs_pkg::MSEL_K2;
        mul_k_d   = bfs_pkg::MM_C1;
        mul_ret_d = S_T2;
        state_d   = S_MUL;
      end
      S_T2: begin
        h2_d      = h2_q ^ k2_q;
        mul_sel_d = bfs_pkg::MSEL_K1;
        mul_k_d   = bfs_pkg::MM_C1;
        mul_ret_d = S_T3;
        state_d   = S_MUL;
      end
      S_T3: begin
        k1_d      = rotl(k1_q, 31);
        mul_sel_d = bfs_pkg::MSEL_K1;
        mul_k_d   = bfs_pkg::MM_C2;
        mul_ret_d = S_T4;
        state_d   = S_MUL;
      end
      S_T4: begin
        h1_d    = h1_q ^ k1_q;
        state_d = S_F0;
      end
      S_F0: begin
        h1_d    = h1_q ^ 64'(len_q);
        h2_d    = h2_q ^ 64'(len_q);
        state_d = S_F1;
      end
      S_F1: begin
        h1_d    = h1_q + h2_q;
        state_d = S_F2;
      end
      S_F2: begin
        h2_d    = h2_q + h1_q;
        state_d = S_F3;
      end
      S_F3: begin
        h1_d      = h1_q ^ (h1_q >> 33);
        mul_sel_d = bfs_pkg::MSEL_H1;
        mul_k_d   = bfs_pkg::MM_F1;
        mul_ret_d = S_F4;
        state_d   = S_MUL;
      end
      S_F4: begin
        h1_d      = h1_q ^ (h1_q >> 33);
        mul_sel_d = bfs_pkg::MSEL_H1;
        mul_k_d   = bfs_pkg::MM_F2;
        mul_ret_d = S_F5;
        state_d   = S_MUL;
      end
      S_F5: begin
        h1_d      = h1_q ^ (h1_q >> 33);
        h2_d      = h2_q ^ (h2_q >> 33);
        mul_sel_d = bfs_pkg::MSEL_H2;
        mul_k_d   = bfs_pkg::MM_F1;
        mul_ret_d = S_F6;
        state_d   = S_MUL;
      end
      S_F6: begin
        h2_d      = h2_q ^ (h2_q >> 33);
        mul_sel_d = bfs_pkg::MSEL_H2;
        mul_k_d   = bfs_pkg::MM_F2;
        mul_ret_d = S_F7;
        state_d   = S_MUL;
      end
      S_F7: begin
        h2_d    = h2_q ^ (h2_q >> 33);
        state_d = S_F8;
      end
      S_F8: begin
        h1_d    = h1_q + h2_q;
        rem_d   = '0;
        mcnt_d  = '0;
        state_d = S_MOD;
      end
      S_MOD: begin
        // restoring remainder, one bit of h1 per cycle
        h1_d   = h1_q << 1;
        rem_d  = (mod_t >= {1'b0, modulus}) ? MW'(mod_t - {1'b0, modulus}) : MW'(mod_t);
        mcnt_d = mcnt_q + 6'd1;
        if (mcnt_q == 6'd63) state_d = S_PRB;
      end
      S_PRB: begin
        if (is_add_q) begin
          fr_we    = 1'b1;
          fr_wdata = 1'b1;
          seed_d   = seed_nxt;
          state_d  = (seed_nxt == n_q) ? S_DONE : S_SEED;
        end else begin
          state_d = S_PRW;
        end
      end
      S_PRW: begin
        if (!fr_rdata) begin
          answer_d = 1'b0;
          state_d  = S_DONE;
        end else begin
          seed_d  = seed_nxt;
          state_d = (seed_nxt == n_q) ? S_DONE : S_SEED;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          maybe_d     = answer_q && !is_add_q;
          too_long_d  = 1'b0;
          out_stat_d  = stat_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      mul_ret_q    <= S_IDLE;
      msub_q       <= '0;
      mul_sel_q    <= bfs_pkg::MSEL_K1;
      ld_cnt_q     <= '0;
      base_q       <= '0;
      remn_q       <= '0;
      len_q        <= '0;
      key_len_q    <= '0;
      ovf_q        <= 1'b0;
      seed_q       <= '0;
      n_q          <= '0;
      is_add_q     <= 1'b0;
      answer_q     <= 1'b0;
      mcnt_q       <= '0;
      clr_cnt_q    <= '0;
      stat_q       <= bfs_pkg::ST_DISABLED;
      bit_count_q  <= bfs_pkg::BIT_COUNT_RST;
      hash_count_q <= bfs_pkg::HASH_COUNT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mul_ret_q    <= mul_ret_d;
      msub_q       <= msub_d;
      mul_sel_q    <= mul_sel_d;
      ld_cnt_q     <= ld_cnt_d;
      base_q       <= base_d;
      remn_q       <= remn_d;
      len_q        <= len_d;
      key_len_q    <= key_len_d;
      ovf_q        <= ovf_d;
      seed_q       <= seed_d;
      n_q          <= n_d;
      is_add_q     <= is_add_d;
      answer_q     <= answer_d;
      mcnt_q       <= mcnt_d;
      clr_cnt_q    <= clr_cnt_d;
      stat_q       <= stat_d;
      bit_count_q  <= bit_count_d;
      hash_count_q <= hash_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q       <= h1_d;
    h2_q       <= h2_d;
    k1_q       <= k1_d;
    k2_q       <= k2_d;
    acc_q      <= acc_d;
    mul_k_q    <= mul_k_d;
    rem_q      <= rem_d;
    maybe_q    <= maybe_d;
    too_long_q <= too_long_d;
    out_stat_q <= out_stat_d;
  end

  assign in_ready_o      = in_ready;
  assign out_valid_o     = out_valid_q;
  assign maybe_present_o = maybe_q;
  assign status_now_o    = out_stat_q;
  assign key_too_long_o  = too_long_q;

endmodule

@@ rtl/core/bfs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_ram
// Single-port RAM with one write or read per cycle and registered read data.
// ----------------------------------------------------------------------------
module bfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
